// ===== rtl/bpfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;
	localparam int PAGES = 65536;
	localparam int MAX_RUN = 64;
	localparam int PW = $clog2(PAGES);
	localparam int CW = PW + 1;
	localparam int WORD_BITS = 64;
	localparam int WB = $clog2(WORD_BITS);
	localparam int WORDS = PAGES / WORD_BITS;
	localparam int AW = PW - WB;

	localparam logic [2:0] OP_REQ_PAGE = 3'd0;
	localparam logic [2:0] OP_REQ_RUN = 3'd1;
	localparam logic [2:0] OP_FREE = 3'd2;
	localparam logic [2:0] OP_LOCK = 3'd3;
	localparam logic [2:0] OP_RESERVE = 3'd4;
	localparam logic [2:0] OP_UNRESERVE = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAME = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	localparam logic [1:0] ST_BAD = 2'd3;

	// memory port bundle from sequencer to bitmap
	typedef struct packed {
		logic rd;
		logic [AW-1:0] raddr;
		logic wr;
		logic [AW-1:0] waddr;
		logic [WORD_BITS-1:0] wdata;
	} mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/bpfa_bitmap.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpfa_bitmap (
	input wire logic clk,
	input wire logic arst_n,
	input wire bpfa_pkg::mem_req_t req,
	output logic [bpfa_pkg::WORD_BITS-1:0] rdata,
	output logic clearing
);
	import bpfa_pkg::*;
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [AW:0] clr_q;
	logic [WORD_BITS-1:0] rdata_q;

	assign clearing = !clr_q[AW];
	assign rdata = rdata_q;

	// clearing pass after reset, one word a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (clearing) mem[clr_q[AW-1:0]] <= '0;
		else if (req.wr) mem[req.waddr] <= req.wdata;
		if (req.rd) rdata_q <= mem[req.raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/bpfa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpfa_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] operation,
	input wire logic [15:0] page_index,
	input wire logic [6:0] run_length,
	input wire logic clearing,
	input wire logic [bpfa_pkg::WORD_BITS-1:0] rdata,
	output bpfa_pkg::mem_req_t req,
	output logic busy,
	output logic done,
	output logic [1:0] status,
	output logic [15:0] found_page,
	output logic [16:0] free_pages,
	output logic [16:0] used_pages,
	output logic [16:0] reserved_pages
);
	import bpfa_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_MARK_RD = 7'b0001000,
		S_MARK = 7'b0010000,
		S_SINGLE = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t st_q;
	logic [2:0] op_q;
	logic [PW-1:0] idx_q, pos_q, run_start_q, hint_q, mark_q;
	logic [6:0] want_q, cnt_q, left_q;
	logic pass2_q;
	logic [CW-1:0] free_q, used_q, res_q;
	logic [1:0] status_q;
	logic [15:0] found_q;
	logic done_q;

	logic cur_bit;
	logic [PW:0] pos_nx;
	logic [WB-1:0] bsel;

	assign bsel = pos_q[WB-1:0];
	assign cur_bit = rdata[bsel];
	assign pos_nx = {1'b0, pos_q} + 1'b1;

	assign busy = (st_q != S_IDLE) || clearing;
	assign done = done_q;
	assign status = status_q;
	assign found_page = found_q;
	assign free_pages = free_q[16:0];
	assign used_pages = used_q[16:0];
	assign reserved_pages = res_q[16:0];

	always_comb begin
		req = '0;
		case (st_q)
			S_RD: begin
				req.rd = 1'b1;
				req.raddr = pos_q[PW-1:WB];
			end
			S_SINGLE: begin
				req.rd = 1'b1;
				req.raddr = idx_q[PW-1:WB];
			end
			S_MARK_RD: begin
				req.rd = 1'b1;
				req.raddr = mark_q[PW-1:WB];
			end
			S_MARK: begin
				req.wr = 1'b1;
				req.waddr = mark_q[PW-1:WB];
				req.wdata = rdata | (WORD_BITS'(1) << mark_q[WB-1:0]);
			end
			S_DONE: begin
				if (op_q != OP_REQ_PAGE && op_q != OP_REQ_RUN && status_q == ST_OK) begin
					req.wr = 1'b1;
					req.waddr = idx_q[PW-1:WB];
					req.wdata = (op_q == OP_LOCK || op_q == OP_RESERVE)
						? rdata | (WORD_BITS'(1) << idx_q[WB-1:0])
						: rdata & ~(WORD_BITS'(1) << idx_q[WB-1:0]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			hint_q <= '0;
			free_q <= CW'(PAGES);
			used_q <= '0;
			res_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			found_q <= '0;
			op_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			run_start_q <= '0;
			mark_q <= '0;
			want_q <= '0;
			cnt_q <= '0;
			left_q <= '0;
			pass2_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start && !clearing) begin
						op_q <= operation;
						idx_q <= PW'(page_index);
						found_q <= '0;
						status_q <= ST_OK;
						pos_q <= hint_q;
						cnt_q <= '0;
						pass2_q <= 1'b0;
						run_start_q <= hint_q;
						if (operation == OP_REQ_PAGE || operation == OP_REQ_RUN) begin
							want_q <= (operation == OP_REQ_PAGE) ? 7'd1 : run_length;
							if (operation == OP_REQ_RUN && (run_length == 7'd0 ||
								32'(run_length) > MAX_RUN || 32'(run_length) > PAGES)) begin
								status_q <= ST_BAD;
								st_q <= S_DONE;
							end else st_q <= S_RD;
						end else if (operation > OP_UNRESERVE ||
							32'(page_index) >= PAGES) begin
							status_q <= ST_BAD;
							st_q <= S_DONE;
						end else st_q <= S_SINGLE;
					end
				end
				S_RD: st_q <= S_SCAN;
				S_SCAN: begin
					// one bit per cycle; reread on word change
					if (cur_bit) cnt_q <= '0;
					else begin
						if (cnt_q == 7'd0) run_start_q <= pos_q;
						cnt_q <= cnt_q + 1'b1;
					end
					if (!cur_bit && cnt_q + 1'b1 == want_q) begin
						found_q <= 16'((cnt_q == 7'd0) ? pos_q : run_start_q);
						mark_q <= (cnt_q == 7'd0) ? pos_q : run_start_q;
						hint_q <= (cnt_q == 7'd0) ? pos_q : run_start_q;
						left_q <= want_q;
						st_q <= S_MARK_RD;
					end else if (pos_nx[PW]) begin
						if (pass2_q) begin
							status_q <= ST_NOSPACE;
							hint_q <= '0;
							st_q <= S_DONE;
						end else begin
							pass2_q <= 1'b1;
							pos_q <= '0;
							cnt_q <= '0;
							st_q <= S_RD;
						end
					end else begin
						pos_q <= pos_nx[PW-1:0];
						if (pos_nx[WB-1:0] == '0) st_q <= S_RD;
					end
				end
				S_MARK_RD: st_q <= S_MARK;
				S_MARK: begin
					free_q <= (free_q == '0) ? '0 : free_q - 1'b1;
					used_q <= used_q + 1'b1;
					mark_q <= mark_q + 1'b1;
					left_q <= left_q - 1'b1;
					if (left_q == 7'd1) st_q <= S_DONE;
					else st_q <= S_MARK_RD;
				end
				S_SINGLE: st_q <= S_DONE;
				S_DONE: begin
					if (op_q != OP_REQ_PAGE && op_q != OP_REQ_RUN && status_q == ST_OK) begin
						if (op_q == OP_LOCK || op_q == OP_RESERVE) begin
							if (rdata[idx_q[WB-1:0]]) status_q <= ST_SAME;
							else begin
								free_q <= (free_q == '0) ? '0 : free_q - 1'b1;
								if (op_q == OP_RESERVE) res_q <= res_q + 1'b1;
								else used_q <= used_q + 1'b1;
							end
						end else begin
							if (!rdata[idx_q[WB-1:0]]) status_q <= ST_SAME;
							else begin
								free_q <= free_q + 1'b1;
								if (op_q == OP_UNRESERVE)
									res_q <= (res_q == '0) ? '0 : res_q - 1'b1;
								else used_q <= (used_q == '0) ? '0 : used_q - 1'b1;
								if (hint_q > idx_q) hint_q <= idx_q;
							end
						end
					end
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Bad requests go straight from start to the done state; single-page operations first
// read their bitmap word. Page and run requests scan one bitmap bit per cycle from the
// hint, rereading on each 64-bit word and wrapping once, then mark each granted page.
// One operation at a time; busy is high until done. The receiver cannot stall.
// After reset a clearing pass zeroes the bitmap with busy high.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] operation,
	input wire logic [15:0] page_index,
	input wire logic [6:0] run_length,
	output logic done,
	output logic [1:0] status,
	output logic [15:0] found_page,
	output logic [16:0] free_pages,
	output logic [16:0] used_pages,
	output logic [16:0] reserved_pages
);
	import bpfa_pkg::*;
	mem_req_t req;
	logic [WORD_BITS-1:0] rdata;
	logic clearing;

	bpfa_bitmap u_bitmap (.clk, .arst_n, .req, .rdata, .clearing);
	bpfa_seq u_seq (.clk, .arst_n, .start, .operation, .page_index, .run_length,
		.clearing, .rdata, .req, .busy, .done, .status, .found_page,
		.free_pages, .used_pages, .reserved_pages);

`ifndef SYNTHESIS
	a_done_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> found_page == '0) else $error("grant on failure");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	a_no_rw_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done) else $error("done during clear");
`endif
endmodule
`default_nettype wire

// ===== sim/bitmap_page_frame_allocator_test.sv =====
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_test;
	import bpfa_pkg::*;

	localparam int N_RANDOM = 1730;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int NO_IDLE_FROM = 1000;
	localparam int NO_IDLE_TO = 1300;
	localparam int DRAIN_AT = 900;

	typedef struct {
		logic [2:0] op;
		logic [15:0] idx;
		logic [6:0] len;
	} alloc_cmd_t;

	typedef struct {
		logic [1:0] status;
		logic [15:0] found;
		logic [16:0] free_n;
		logic [16:0] used_n;
		logic [16:0] rsvd_n;
	} alloc_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] operation = '0;
	logic [15:0] page_index = '0;
	logic [6:0] run_length = '0;
	wire busy, done;
	wire [1:0] status;
	wire [15:0] found_page;
	wire [16:0] free_pages, used_pages, reserved_pages;

	bitmap_page_frame_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .page_index(page_index), .run_length(run_length),
		.done(done), .status(status), .found_page(found_page),
		.free_pages(free_pages), .used_pages(used_pages),
		.reserved_pages(reserved_pages)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	alloc_cmd_t pending_cmds[$];
	alloc_rsp_t expected_rsps[$];
	int errors = 0;
	int cycles = 0;
	int issued = 0;
	logic taken_last = 1'b0;

	// predictor state
	bit occ[PAGES];
	int hint;
	int free_cnt, used_cnt, rsvd_cnt;

	function automatic int scan_run(int from, int len);
		int count;
		count = 0;
		for (int p = from; p < PAGES; p++) begin
			if (occ[p]) begin
				count = 0;
			end else begin
				count++;
				if (count == len)
					return p + 1 - len;
			end
		end
		return -1;
	endfunction

	function automatic void grab(int p, bit as_rsvd);
		occ[p] = 1'b1;
		free_cnt = (free_cnt > 0) ? free_cnt - 1 : 0;
		if (as_rsvd)
			rsvd_cnt++;
		else
			used_cnt++;
	endfunction

	function automatic alloc_rsp_t predict_alloc(alloc_cmd_t c);
		alloc_rsp_t r;
		int want, s;
		r.status = ST_OK;
		r.found = '0;
		if (c.op == OP_REQ_PAGE || c.op == OP_REQ_RUN) begin
			want = (c.op == OP_REQ_PAGE) ? 1 : int'(c.len);
			if (want == 0 || want > MAX_RUN || want > PAGES) begin
				r.status = ST_BAD;
			end else begin
				s = scan_run(hint, want);
				if (s < 0)
					s = scan_run(0, want);
				if (s < 0) begin
					r.status = ST_NOSPACE;
					hint = 0;
				end else begin
					for (int k = 0; k < want; k++)
						grab(s + k, 1'b0);
					r.found = s[15:0];
					hint = s;
				end
			end
		end else if (c.op >= OP_FREE && c.op <= OP_UNRESERVE) begin
			if (int'(c.idx) >= PAGES) begin
				r.status = ST_BAD;
			end else if (c.op == OP_FREE || c.op == OP_UNRESERVE) begin
				if (!occ[c.idx]) begin
					r.status = ST_SAME;
				end else begin
					occ[c.idx] = 1'b0;
					free_cnt++;
					if (c.op == OP_UNRESERVE)
						rsvd_cnt = (rsvd_cnt > 0) ? rsvd_cnt - 1 : 0;
					else
						used_cnt = (used_cnt > 0) ? used_cnt - 1 : 0;
					if (hint > int'(c.idx))
						hint = c.idx;
				end
			end else begin
				if (occ[c.idx])
					r.status = ST_SAME;
				else
					grab(c.idx, c.op == OP_RESERVE);
			end
		end else begin
			r.status = ST_BAD;
		end
		r.free_n = free_cnt[16:0];
		r.used_n = used_cnt[16:0];
		r.rsvd_n = rsvd_cnt[16:0];
		return r;
	endfunction

	// check results, then record any transfer into the block
	always @(posedge clk) begin
		alloc_rsp_t e;
		alloc_cmd_t c;
		cycles <= cycles + 1;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d page %0d", status, found_page);
			end else begin
				e = expected_rsps.pop_front();
				if (status !== e.status || found_page !== e.found || free_pages !== e.free_n
						|| used_pages !== e.used_n || reserved_pages !== e.rsvd_n) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
							e.status, e.found, e.free_n, e.used_n, e.rsvd_n, status,
							found_page, free_pages, used_pages, reserved_pages);
				end
			end
		end
		if (start && !busy) begin
			c.op = operation;
			c.idx = page_index;
			c.len = run_length;
			expected_rsps.push_back(predict_alloc(c));
		end
		taken_last <= start && !busy;
	end

	always @(negedge clk) begin
		alloc_cmd_t c;
		logic go;
		bit may_idle;
		go = 1'b0;
		if (arst_n && (!start || taken_last)) begin
			may_idle = issued < NO_IDLE_FROM || issued > NO_IDLE_TO;
			if (pending_cmds.size() == 0) begin
				go = 1'b0;
			end else if (issued == DRAIN_AT && (expected_rsps.size() != 0 || busy)) begin
				go = 1'b0;
			end else if (may_idle && $urandom_range(99) < 11) begin
				go = 1'b0;
			end else begin
				c = pending_cmds.pop_front();
				operation <= c.op;
				page_index <= c.idx;
				run_length <= c.len;
				issued++;
				go = 1'b1;
			end
			start <= go;
		end
	end

	function automatic alloc_cmd_t mk(logic [2:0] op, logic [15:0] idx, logic [6:0] len);
		alloc_cmd_t c;
		c.op = op;
		c.idx = idx;
		c.len = len;
		return c;
	endfunction

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL bitmap_page_frame_allocator");
			$finish;
		end
	end

	initial begin
		int w;
		alloc_cmd_t c;
		for (int p = 0; p < PAGES; p++)
			occ[p] = 1'b0;
		hint = 0;
		free_cnt = PAGES;
		used_cnt = 0;
		rsvd_cnt = 0;

		pending_cmds.push_back(mk(OP_REQ_PAGE, 16'hffff, 7'h7f));
		pending_cmds.push_back(mk(OP_REQ_RUN, 16'h0, 7'd64));
		pending_cmds.push_back(mk(OP_REQ_RUN, 16'h0, 7'd0));
		pending_cmds.push_back(mk(OP_REQ_RUN, 16'h0, 7'd65));
		pending_cmds.push_back(mk(OP_REQ_RUN, 16'h0, 7'd127));
		pending_cmds.push_back(mk(OP_FREE, 16'hffff, 7'd0));
		pending_cmds.push_back(mk(OP_LOCK, 16'hffff, 7'd0));
		pending_cmds.push_back(mk(OP_LOCK, 16'hffff, 7'd0));
		pending_cmds.push_back(mk(OP_RESERVE, 16'hfffe, 7'd0));
		pending_cmds.push_back(mk(OP_RESERVE, 16'hfffe, 7'd0));
		pending_cmds.push_back(mk(OP_UNRESERVE, 16'hfffe, 7'd0));
		pending_cmds.push_back(mk(OP_UNRESERVE, 16'hfffe, 7'd0));
		pending_cmds.push_back(mk(OP_FREE, 16'hffff, 7'd0));
		pending_cmds.push_back(mk(OP_FREE, 16'd0, 7'd0));
		pending_cmds.push_back(mk(3'd6, 16'd3, 7'd3));
		pending_cmds.push_back(mk(3'd7, 16'd3, 7'd3));
		// mixed release: reserved page freed, locked page unreserved
		pending_cmds.push_back(mk(OP_RESERVE, 16'd100, 7'd0));
		pending_cmds.push_back(mk(OP_FREE, 16'd100, 7'd0));
		pending_cmds.push_back(mk(OP_LOCK, 16'd5, 7'd0));
		pending_cmds.push_back(mk(OP_UNRESERVE, 16'd5, 7'd0));
		pending_cmds.push_back(mk(OP_REQ_RUN, 16'd0, 7'd1));
		pending_cmds.push_back(mk(OP_REQ_PAGE, 16'd0, 7'd0));

		for (int i = 0; i < N_RANDOM; i++) begin
			w = $urandom_range(99);
			c.idx = ($urandom_range(99) < 75) ? 16'($urandom_range(1023)) : 16'($urandom);
			c.len = 7'($urandom_range(1, 8));
			if (w < 30) begin
				c.op = OP_REQ_PAGE;
				c.len = 7'($urandom);
			end else if (w < 45) begin
				c.op = OP_REQ_RUN;
				if ($urandom_range(9) == 0)
					c.len = 7'($urandom);
				else if ($urandom_range(4) == 0)
					c.len = 7'($urandom_range(1, MAX_RUN));
			end else if (w < 70) begin
				c.op = OP_FREE;
			end else if (w < 80) begin
				c.op = OP_LOCK;
			end else if (w < 89) begin
				c.op = OP_RESERVE;
			end else if (w < 98) begin
				c.op = OP_UNRESERVE;
			end else begin
				c.op = 3'($urandom_range(6, 7));
			end
			pending_cmds.push_back(c);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_cmds.size() == 0);
		@(posedge clk);
		while (start || busy || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("PASS bitmap_page_frame_allocator");
		else
			$display("FAIL bitmap_page_frame_allocator");
		$finish;
	end
endmodule
